>>> design/bpdc_pkg.sv
// Package for the button press duration classifier.
// Holds the request and status codes, the state enum and the shared structs.
// No dependencies.
package bpdc_pkg;

  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef enum logic [1:0] {
    STAT_NONE  = 2'd0,
    STAT_ADDED = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_FIRED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } seq_state_t;

  // one handler entry as held in the table
  typedef struct packed {
    logic [7:0]  target;
    logic [7:0]  kind;
    logic [15:0] thr;
    logic [7:0]  tag;
  } entry_t;

  // operands for the shared compare unit, one entry per cycle
  typedef struct packed {
    logic        valid;
    logic [15:0] thr;
    logic        elap_hi;
    logic [15:0] elap_lo;
    logic        found;
    logic [15:0] best_thr;
  } cmp_req_t;

endpackage

>>> design/bpdc_table.sv
// Handler table: entry registers with valid bits, one write and one read port.
// Depends on bpdc_pkg.
module bpdc_table
  import bpdc_pkg::*;
#(
  parameter int MAX_HANDLERS = 8,
  parameter int IDX_W        = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  entry_t           wr_data,
  input  logic [IDX_W-1:0] rd_idx,
  output entry_t           rd_data,
  output logic             rd_valid
);

  entry_t                  entry_r [MAX_HANDLERS];
  logic [MAX_HANDLERS-1:0] valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r[wr_idx] <= wr_data;
    end
  end

  always_comb begin
    rd_valid = valid_r[rd_idx];
    rd_data  = rd_valid ? entry_r[rd_idx] : '0;
  end

endmodule

>>> design/bpdc_cmp.sv
// Shared compare unit: tests one entry against the elapsed time and the best so far.
// Depends on bpdc_pkg.
module bpdc_cmp
  import bpdc_pkg::*;
(
  input  cmp_req_t req,
  output logic     hit
);

  logic meets;
  logic better;

  always_comb begin
    meets  = req.elap_hi || (req.elap_lo >= req.thr);
    // strictly larger only, so ties stay with the earlier entry
    better = !req.found || (req.thr > req.best_thr);
    hit    = req.valid && meets && better;
  end

endmodule

>>> design/button_press_duration_classifier_top.sv
// Button press duration classifier, top level.
// Sequencer, press timer and output register; uses bpdc_table, bpdc_cmp, bpdc_pkg.
//
// An add item, and a tick that does not end a press, passes from ST_IDLE through
// ST_DONE, which moves its result into the output register and returns the
// sequencer to ST_IDLE. A tick that releases a press walks the handler table one
// entry per cycle through a single compare unit in ST_SCAN, then passes through
// ST_DONE in the same way. in_ready is high only while the sequencer is idle, so
// an item is taken only after the last one is done. A finished result sits in
// the output register, and the next item may be taken while it waits. If that
// result is still held when the next one is done, the sequencer waits until
// out_ready drains it.
module button_press_duration_classifier_top
  import bpdc_pkg::*;
#(
  parameter int MAX_HANDLERS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic        in_pin_level,
  input  logic [31:0] in_now_ms,
  input  logic [7:0]  in_handler_target,
  input  logic [7:0]  in_handler_kind,
  input  logic [15:0] in_threshold_ms,
  input  logic [7:0]  in_handler_tag,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [2:0]  out_slot,
  output logic [7:0]  out_fired_target,
  output logic [7:0]  out_fired_kind,
  output logic [7:0]  out_fired_tag
);

  localparam int IDX_W = (MAX_HANDLERS > 1) ? $clog2(MAX_HANDLERS) : 1;
  localparam int CNT_W = $clog2(MAX_HANDLERS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_HANDLERS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_HANDLERS);

  seq_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [31:0]      start_r, start_nxt;
  logic             invert_r;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             found_r, found_nxt;
  logic [15:0]      best_thr_r, best_thr_nxt;
  logic             elap_hi_r, elap_hi_nxt;
  logic [15:0]      elap_lo_r, elap_lo_nxt;
  status_t          res_status_r, res_status_nxt;
  logic [2:0]       res_slot_r, res_slot_nxt;
  entry_t           res_entry_r, res_entry_nxt;
  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  logic [2:0]       out_slot_r, out_slot_nxt;
  entry_t           out_entry_r, out_entry_nxt;

  logic             tbl_wr_en;
  entry_t           tbl_wr_data;
  entry_t           rd_data;
  logic             rd_valid;
  cmp_req_t         cmp_req;
  logic             cmp_hit;
  logic [32:0]      diff;
  logic [31:0]      start_eff;
  logic             pressed;

  bpdc_table #(
    .MAX_HANDLERS (MAX_HANDLERS),
    .IDX_W        (IDX_W)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (tbl_wr_en),
    .wr_idx   (count_r[IDX_W-1:0]),
    .wr_data  (tbl_wr_data),
    .rd_idx   (idx_r),
    .rd_data  (rd_data),
    .rd_valid (rd_valid)
  );

  bpdc_cmp u_cmp (
    .req (cmp_req),
    .hit (cmp_hit)
  );

  always_comb begin
    tbl_wr_data.target = in_handler_target;
    tbl_wr_data.kind   = in_handler_kind;
    tbl_wr_data.thr    = in_threshold_ms;
    tbl_wr_data.tag    = in_handler_tag;

    cmp_req.valid    = rd_valid && (state_r == ST_SCAN);
    cmp_req.thr      = rd_data.thr;
    cmp_req.elap_hi  = elap_hi_r;
    cmp_req.elap_lo  = elap_lo_r;
    cmp_req.found    = found_r;
    cmp_req.best_thr = best_thr_r;
  end

  // borrow out says the clock has wrapped below the start time
  assign diff      = {1'b0, in_now_ms} - {1'b0, start_r};
  assign start_eff = diff[32] ? in_now_ms : start_r;
  assign pressed   = in_pin_level ^ invert_r;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    start_nxt      = start_r;
    idx_nxt        = idx_r;
    found_nxt      = found_r;
    best_thr_nxt   = best_thr_r;
    elap_hi_nxt    = elap_hi_r;
    elap_lo_nxt    = elap_lo_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_entry_nxt  = res_entry_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_entry_nxt  = out_entry_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    tbl_wr_en      = 1'b0;
    in_ready       = (state_r == ST_IDLE);

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          res_status_nxt = STAT_NONE;
          res_slot_nxt   = '0;
          res_entry_nxt  = '0;
          state_nxt      = ST_DONE;
          if (in_req_type == REQ_ADD) begin
            if (count_r >= FULL_CNT) begin
              res_status_nxt = STAT_FULL;
            end else begin
              tbl_wr_en      = 1'b1;
              count_nxt      = count_r + 1'b1;
              res_status_nxt = STAT_ADDED;
              res_slot_nxt   = 3'(count_r);
            end
          end else begin
            if (pressed && start_eff == '0) begin
              start_nxt = in_now_ms;
            end else if (!pressed && start_eff != '0) begin
              // after a wrap the start is now, so elapsed is zero
              start_nxt    = '0;
              elap_hi_nxt  = !diff[32] && (diff[31:16] != '0);
              elap_lo_nxt  = diff[32] ? '0 : diff[15:0];
              idx_nxt      = '0;
              found_nxt    = 1'b0;
              best_thr_nxt = '0;
              state_nxt    = ST_SCAN;
            end else begin
              start_nxt = start_eff;
            end
          end
        end
      end
      ST_SCAN: begin
        if (cmp_hit) begin
          found_nxt     = 1'b1;
          best_thr_nxt  = rd_data.thr;
          res_entry_nxt = rd_data;
        end
        if (idx_r == LAST_IDX) begin
          res_status_nxt = (found_r || cmp_hit) ? STAT_FIRED : STAT_NONE;
          state_nxt      = ST_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          out_entry_nxt  = res_entry_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      start_r     <= '0;
      invert_r    <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      found_r     <= found_nxt;
      if (cfg_wr_en) begin
        invert_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    best_thr_r   <= best_thr_nxt;
    elap_hi_r    <= elap_hi_nxt;
    elap_lo_r    <= elap_lo_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_entry_r  <= res_entry_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_entry_r  <= out_entry_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_slot         = out_slot_r;
  assign out_fired_target = out_entry_r.target;
  assign out_fired_kind   = out_entry_r.kind;
  assign out_fired_tag    = out_entry_r.tag;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count beyond table size");

  a_scan_idle_press: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (start_r == '0))
    else $error("press start not cleared during release scan");

  a_add_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_req_type == REQ_ADD && count_r < FULL_CNT)
      |=> (count_r == $past(count_r) + 1'b1))
    else $error("add item did not advance entry count");

  a_fired_has_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && res_status_r == STAT_FIRED) |-> found_r)
    else $error("fired result without a matching entry");

endmodule

>>> bench/button_press_duration_classifier_top_tb.sv
// Testbench for button_press_duration_classifier_top.
// A press-duration classifier model predicts every result; the results are checked
// in order. Depends on bpdc_pkg and the design files.
module button_press_duration_classifier_top_tb
  import bpdc_pkg::*;
();

  localparam int MAX_HND     = 8;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic        req;
    logic        pin;
    logic [31:0] now;
    logic [7:0]  target;
    logic [7:0]  kind;
    logic [15:0] thr;
    logic [7:0]  tag;
  } button_req_t;

  typedef struct packed {
    status_t    status;
    logic [2:0] slot;
    logic [7:0] target;
    logic [7:0] kind;
    logic [7:0] tag;
  } press_result_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic        in_req_type;
  logic        in_pin_level;
  logic [31:0] in_now_ms;
  logic [7:0]  in_handler_target;
  logic [7:0]  in_handler_kind;
  logic [15:0] in_threshold_ms;
  logic [7:0]  in_handler_tag;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [2:0]  out_slot;
  logic [7:0]  out_fired_target;
  logic [7:0]  out_fired_kind;
  logic [7:0]  out_fired_tag;

  // classifier model state
  logic [15:0] hnd_thr    [MAX_HND];
  logic [7:0]  hnd_target [MAX_HND];
  logic [7:0]  hnd_kind   [MAX_HND];
  logic [7:0]  hnd_tag    [MAX_HND];
  int          hnd_count;
  logic [31:0] press_start_ms;
  logic        invert_model;

  press_result_t pending_results[$];
  int            n_sent;
  int            pending_gap;
  int            cycle_cnt = 0;
  bit            no_idle;
  bit            hold_req;
  bit            failed;
  logic [31:0]   ms_now;

  button_press_duration_classifier_top #(
    .MAX_HANDLERS(MAX_HND)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_pin_level     (in_pin_level),
    .in_now_ms        (in_now_ms),
    .in_handler_target(in_handler_target),
    .in_handler_kind  (in_handler_kind),
    .in_threshold_ms  (in_threshold_ms),
    .in_handler_tag   (in_handler_tag),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_slot         (out_slot),
    .out_fired_target (out_fired_target),
    .out_fired_kind   (out_fired_kind),
    .out_fired_tag    (out_fired_tag)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // works out the result of one item and updates the model state
  function automatic press_result_t classify_item(button_req_t it);
    press_result_t r;
    logic          pressed;
    logic [31:0]   elapsed;
    int            best;
    bit            found;
    r = '0;
    r.status = STAT_NONE;
    if (it.req == REQ_ADD) begin
      if (hnd_count >= MAX_HND) begin
        r.status = STAT_FULL;
      end else begin
        hnd_target[hnd_count] = it.target;
        hnd_kind[hnd_count]   = it.kind;
        hnd_thr[hnd_count]    = it.thr;
        hnd_tag[hnd_count]    = it.tag;
        r.status = STAT_ADDED;
        r.slot   = 3'(hnd_count);
        hnd_count++;
      end
      return r;
    end
    pressed = it.pin ^ invert_model;
    // clock went backwards during a press: restart from now
    if (press_start_ms != 0 && press_start_ms > it.now) press_start_ms = it.now;
    if (pressed && press_start_ms == 0) begin
      press_start_ms = it.now;
    end else if (!pressed && press_start_ms != 0) begin
      elapsed = it.now - press_start_ms;
      found   = 1'b0;
      best    = 0;
      for (int k = 0; k < hnd_count; k++) begin
        if (elapsed >= {16'd0, hnd_thr[k]} && (!found || hnd_thr[k] > hnd_thr[best])) begin
          best  = k;
          found = 1'b1;
        end
      end
      press_start_ms = 0;
      if (found) begin
        r.status = STAT_FIRED;
        r.target = hnd_target[best];
        r.kind   = hnd_kind[best];
        r.tag    = hnd_tag[best];
      end
    end
    return r;
  endfunction

  // valid stays high into the next item when no gap follows
  task automatic send_item(input button_req_t it);
    if (pending_gap > 0) repeat (pending_gap) @(posedge clk);
    in_req_type       <= it.req;
    in_pin_level      <= it.pin;
    in_now_ms         <= it.now;
    in_handler_target <= it.target;
    in_handler_kind   <= it.kind;
    in_threshold_ms   <= it.thr;
    in_handler_tag    <= it.tag;
    in_valid          <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(classify_item(it));
    n_sent++;
    pending_gap = pick_gap();
    if (pending_gap > 0) in_valid <= 1'b0;
  endtask

  task automatic send_tick(input logic pressed, input logic [31:0] now);
    button_req_t it;
    it.req    = REQ_TICK;
    it.pin    = pressed ^ invert_model;
    it.now    = now;
    it.target = 8'($urandom);
    it.kind   = 8'($urandom);
    it.thr    = 16'($urandom);
    it.tag    = 8'($urandom);
    send_item(it);
  endtask

  task automatic send_add(input logic [7:0] target, input logic [7:0] kind,
                          input logic [15:0] thr, input logic [7:0] tag);
    button_req_t it;
    it.req    = REQ_ADD;
    it.pin    = 1'($urandom);
    it.now    = $urandom;
    it.target = target;
    it.kind   = kind;
    it.thr    = thr;
    it.tag    = tag;
    send_item(it);
  endtask

  task automatic stop_input();
    if (pending_gap == 0) in_valid <= 1'b0;
    pending_gap = 0;
  endtask

  task automatic wait_idle();
    stop_input();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic cfg_write(input logic v);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    invert_model = v;
  endtask

  // durations near a held threshold, short ones, and anything up past the maximum
  function automatic logic [31:0] pick_duration();
    int          r;
    logic [31:0] d;
    r = $urandom_range(0, 9);
    if (hnd_count > 0 && r < 5) begin
      d = {16'd0, hnd_thr[$urandom_range(0, hnd_count - 1)]};
      case ($urandom_range(0, 2))
        0: if (d > 0) d = d - 1;
        1: d = d + 1;
        default: ;
      endcase
    end else if (r < 8) begin
      d = $urandom_range(0, 300);
    end else begin
      d = $urandom_range(0, 70000);
    end
    return d;
  endfunction

  task automatic rand_add();
    int          r;
    logic [15:0] thr;
    r = $urandom_range(0, 9);
    if (r < 4) thr = 16'($urandom_range(0, 300));
    else if (r < 7) thr = 16'($urandom);
    else if (r == 7) thr = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    else if (hnd_count > 0) thr = hnd_thr[$urandom_range(0, hnd_count - 1)];
    else thr = 16'($urandom);
    send_add(8'($urandom), 8'($urandom), thr, 8'($urandom));
  endtask

  task automatic rand_press_seq();
    int          r;
    int          n_hold;
    logic [31:0] start;
    logic [31:0] dur;
    r = $urandom_range(0, 19);
    if (r == 0) ms_now = 0;
    else if (r == 1) ms_now = $urandom;
    else if (r == 2) ms_now = 32'hFFFF_FFFF - $urandom_range(0, 70000);
    start  = ms_now;
    dur    = pick_duration();
    n_hold = $urandom_range(0, 3);
    send_tick(1'b1, start);
    for (int i = 1; i <= n_hold; i++) send_tick(1'b1, start + (dur * i) / (n_hold + 1));
    send_tick(1'b0, start + dur);
    ms_now = start + dur + $urandom_range(1, 500);
  endtask

  // press, then the clock reads earlier than the press start
  task automatic rand_wrap_seq();
    logic [31:0] start;
    logic [31:0] early;
    start = $urandom | 32'h1;
    early = $urandom_range(0, start - 1);
    send_tick(1'b1, start);
    if ($urandom_range(0, 1)) begin
      send_tick(1'b1, early);
      send_tick(1'b0, early + pick_duration());
    end else begin
      send_tick(1'b0, early);
    end
    ms_now = early + 1000;
  endtask

  task automatic run_random_phase(input int stop_at, input int add_pct);
    int r;
    while (n_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < add_pct) rand_add();
      else if (r < add_pct + 10) send_tick(1'($urandom), $urandom);
      else if (r < add_pct + 16) rand_wrap_seq();
      else rand_press_seq();
    end
  endtask

  task automatic test_idle_ticks();
    send_tick(1'b0, 32'h0000_0000);
    send_tick(1'b0, 32'hFFFF_FFFF);
  endtask

  task automatic test_empty_table_release();
    send_tick(1'b1, 32'd100);
    send_tick(1'b0, 32'd200);
  endtask

  task automatic test_add_entries();
    send_add(8'h00, 8'h00, 16'd0,     8'h00);
    send_add(8'hFF, 8'hFF, 16'hFFFF,  8'hFF);
    send_add(8'h5A, 8'hA5, 16'd100,   8'h3C);
    send_add(8'hC3, 8'h0F, 16'd100,   8'hF0);
    send_add(8'h01, 8'h02, 16'd50,    8'h03);
  endtask

  // zero threshold, tie on equal thresholds, the largest threshold, just below one
  task automatic test_thresholds();
    send_tick(1'b1, 32'd1000);
    send_tick(1'b0, 32'd1000);
    send_tick(1'b1, 32'd2000);
    send_tick(1'b0, 32'd2150);
    send_tick(1'b1, 32'd3000);
    send_tick(1'b0, 32'd3000 + 32'd65535);
    send_tick(1'b1, 32'd70000);
    send_tick(1'b0, 32'd70049);
  endtask

  task automatic test_press_at_zero();
    send_tick(1'b1, 32'd0);
    send_tick(1'b0, 32'd40);
  endtask

  task automatic test_clock_wrap();
    send_tick(1'b1, 32'd5000);
    send_tick(1'b1, 32'd10);
    send_tick(1'b0, 32'd70);
  endtask

  task automatic test_held_tick();
    send_tick(1'b1, 32'd100);
    send_tick(1'b1, 32'd120);
    send_tick(1'b0, 32'd131);
  endtask

  task automatic test_wide_time();
    send_tick(1'b1, 32'hFFFF_FF00);
    send_tick(1'b0, 32'hFFFF_FFFF);
  endtask

  task automatic test_table_full();
    while (hnd_count < MAX_HND) rand_add();
    send_add(8'hFF, 8'h00, 16'hFFFF, 8'hAA);
    send_add(8'h00, 8'hFF, 16'h0000, 8'h55);
  endtask

  // receiver holds off while the sender keeps offering items back to back
  task automatic test_receiver_hold();
    int stop_at;
    stop_at  = n_sent + 24;
    no_idle  = 1'b1;
    hold_req = 1'b1;
    while (n_sent < stop_at) rand_press_seq();
    no_idle = 1'b0;
  endtask

  // result receiver
  initial begin
    int n;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    press_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no item waiting: status %0d", out_status);
        failed = 1'b1;
      end else begin
        e = pending_results.pop_front();
        if (out_status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_status);
          failed = 1'b1;
        end
        if (out_slot !== e.slot) begin
          $error("slot: expected %0d, got %0d", e.slot, out_slot);
          failed = 1'b1;
        end
        if (out_fired_target !== e.target) begin
          $error("fired_target: expected %0d, got %0d", e.target, out_fired_target);
          failed = 1'b1;
        end
        if (out_fired_kind !== e.kind) begin
          $error("fired_kind: expected %0d, got %0d", e.kind, out_fired_kind);
          failed = 1'b1;
        end
        if (out_fired_tag !== e.tag) begin
          $error("fired_tag: expected %0d, got %0d", e.tag, out_fired_tag);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    rst_n             <= 1'b0;
    cfg_wr_en         <= 1'b0;
    cfg_wr_data       <= 1'b0;
    in_valid          <= 1'b0;
    in_req_type       <= REQ_ADD;
    in_pin_level      <= 1'b0;
    in_now_ms         <= '0;
    in_handler_target <= '0;
    in_handler_kind   <= '0;
    in_threshold_ms   <= '0;
    in_handler_tag    <= '0;
    for (int k = 0; k < MAX_HND; k++) begin
      hnd_thr[k]    = '0;
      hnd_target[k] = '0;
      hnd_kind[k]   = '0;
      hnd_tag[k]    = '0;
    end
    hnd_count      = 0;
    press_start_ms = '0;
    invert_model   = 1'b0;
    n_sent         = 0;
    pending_gap    = 0;
    no_idle        = 1'b0;
    hold_req       = 1'b0;
    failed         = 1'b0;
    ms_now         = 32'd100000;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_ticks();
    test_empty_table_release();
    test_add_entries();
    test_thresholds();
    test_press_at_zero();
    test_clock_wrap();
    test_held_tick();
    test_wide_time();

    // pull-up wiring while the table is still partly filled
    cfg_write(1'b1);
    run_random_phase(450, 3);
    test_table_full();
    cfg_write(1'b0);
    run_random_phase(850, 8);
    test_receiver_hold();
    cfg_write(1'b1);
    no_idle = 1'b1;
    run_random_phase(1050, 8);
    no_idle = 1'b0;
    run_random_phase(1300, 8);
    cfg_write(1'b0);
    run_random_phase(1730, 8);

    wait_idle();
    repeat (30) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      failed = 1'b1;
    end
    if (!failed) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/bpdc_pkg.sv
design/bpdc_table.sv
design/bpdc_cmp.sv
design/button_press_duration_classifier_top.sv
bench/button_press_duration_classifier_top_tb.sv
